FILE: rtl/core/mutex_table_fifo_handoff_core_assert.svh
// Assertion macros shared by the mutex manager RTL.
`ifndef MUTEX_TABLE_FIFO_HANDOFF_CORE_ASSERT_SVH
`define MUTEX_TABLE_FIFO_HANDOFF_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MTFH_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mutex manager check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MTFH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mutex manager check failed");

`endif

FILE: rtl/core/mtfh_pkg.sv
// Package with codes, widths and shared types of the mutex manager.
package mtfh_pkg;

  // Default sizes of the mutex and thread tables.
  localparam int unsigned MUTEX_COUNT_DEF  = 16;
  localparam int unsigned THREAD_COUNT_DEF = 16;

  // Width of table indexes carried between modules (enough for 256 entries).
  localparam int unsigned IDX_W = 8;

  // Field widths of a request and a response.
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned LOCK_ID_W   = 5;
  localparam int unsigned THREAD_ID_W = 4;
  localparam int unsigned STATUS_W    = 2;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOCK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UNLOCK = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_RES  = 2'd2;

  // One row of the per-mutex table.
  typedef struct packed {
    logic             held;
    logic [IDX_W-1:0] owner;
    logic             nonempty;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
  } row_t;

  // Table contents seen by the decision logic.
  typedef struct packed {
    row_t             row;
    logic [IDX_W-1:0] head_link;
    logic             waiting;
  } tbl_rd_t;

  // Table updates requested by the decision logic.
  typedef struct packed {
    logic             row_we;
    logic [IDX_W-1:0] row_idx;
    row_t             row;
    logic             link_we;
    logic [IDX_W-1:0] link_idx;
    logic [IDX_W-1:0] link;
    logic             wait_we;
    logic [IDX_W-1:0] wait_idx;
    logic             wait_val;
    logic             cnt_inc;
  } tbl_wr_t;

  // Response fields, status in the lowest bits.
  typedef struct packed {
    logic [THREAD_ID_W-1:0] woken_thread;
    logic                   woken_valid;
    logic [LOCK_ID_W-1:0]   new_lock_id;
    logic                   caller_blocked;
    logic [STATUS_W-1:0]    status;
  } result_t;

endpackage

FILE: rtl/core/mtfh_tables.sv
// Per-mutex and per-thread state tables with the created-mutex counter.
module mtfh_tables #(
  parameter int unsigned MUTEX_COUNT  = mtfh_pkg::MUTEX_COUNT_DEF,
  parameter int unsigned THREAD_COUNT = mtfh_pkg::THREAD_COUNT_DEF,
  localparam int unsigned CntW = $clog2(MUTEX_COUNT + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mtfh_pkg::IDX_W-1:0]  rd_mutex_i,
  input  logic [mtfh_pkg::IDX_W-1:0]  rd_thread_i,
  input  mtfh_pkg::tbl_wr_t           wr_i,
  output mtfh_pkg::tbl_rd_t           rd_o,
  output logic [CntW-1:0]             created_o
);

  localparam int unsigned MIW = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam int unsigned TIW = $clog2(THREAD_COUNT);

  logic [CntW-1:0] created_q;
  logic            held_q     [MUTEX_COUNT];
  logic [TIW-1:0]  owner_q    [MUTEX_COUNT];
  logic            nonempty_q [MUTEX_COUNT];
  logic [TIW-1:0]  head_q     [MUTEX_COUNT];
  logic [TIW-1:0]  tail_q     [MUTEX_COUNT];
  logic [TIW-1:0]  link_q     [THREAD_COUNT];
  logic            waiting_q  [THREAD_COUNT];

  logic [MIW-1:0] rd_m;
  logic [TIW-1:0] rd_t;
  logic [TIW-1:0] rd_head;
  logic [MIW-1:0] wr_m;

  assign rd_m    = rd_mutex_i[MIW-1:0];
  assign rd_t    = rd_thread_i[TIW-1:0];
  assign rd_head = head_q[rd_m];
  assign wr_m    = wr_i.row_idx[MIW-1:0];

  // Read the addressed mutex row, the link after its head and the caller's wait flag.
  always_comb begin
    rd_o.row.held     = held_q[rd_m];
    rd_o.row.owner    = mtfh_pkg::IDX_W'(owner_q[rd_m]);
    rd_o.row.nonempty = nonempty_q[rd_m];
    rd_o.row.head     = mtfh_pkg::IDX_W'(rd_head);
    rd_o.row.tail     = mtfh_pkg::IDX_W'(tail_q[rd_m]);
    rd_o.head_link    = mtfh_pkg::IDX_W'(link_q[rd_head]);
    rd_o.waiting      = waiting_q[rd_t];
  end

  assign created_o = created_q;

  // Ownership, queue flags, wait flags and the counter come out of reset cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      created_q <= '0;
      for (int i = 0; i < MUTEX_COUNT; i++) begin
        held_q[i]     <= 1'b0;
        owner_q[i]    <= '0;
        nonempty_q[i] <= 1'b0;
      end
      for (int i = 0; i < THREAD_COUNT; i++) begin
        waiting_q[i] <= 1'b0;
      end
    end else begin
      if (wr_i.cnt_inc) begin
        created_q <= created_q + CntW'(1);
      end
      if (wr_i.row_we) begin
        held_q[wr_m]     <= wr_i.row.held;
        owner_q[wr_m]    <= wr_i.row.owner[TIW-1:0];
        nonempty_q[wr_m] <= wr_i.row.nonempty;
      end
      if (wr_i.wait_we) begin
        waiting_q[wr_i.wait_idx[TIW-1:0]] <= wr_i.wait_val;
      end
    end
  end

  // Queue pointers and links are only read once written.
  always_ff @(posedge clk_i) begin
    if (wr_i.row_we) begin
      head_q[wr_m] <= wr_i.row.head[TIW-1:0];
      tail_q[wr_m] <= wr_i.row.tail[TIW-1:0];
    end
    if (wr_i.link_we) begin
      link_q[wr_i.link_idx[TIW-1:0]] <= wr_i.link[TIW-1:0];
    end
  end

endmodule

FILE: rtl/core/mtfh_decide.sv
// Decision logic: checks a request against the tables and forms updates and response.
module mtfh_decide #(
  parameter int unsigned MUTEX_COUNT  = mtfh_pkg::MUTEX_COUNT_DEF,
  parameter int unsigned THREAD_COUNT = mtfh_pkg::THREAD_COUNT_DEF,
  localparam int unsigned CntW = $clog2(MUTEX_COUNT + 1)
) (
  input  logic                               en_i,
  input  logic [mtfh_pkg::ACTION_W-1:0]      action_i,
  input  logic [mtfh_pkg::LOCK_ID_W-1:0]     lock_id_i,
  input  logic [mtfh_pkg::THREAD_ID_W-1:0]   thread_id_i,
  input  logic [CntW-1:0]                    created_i,
  input  mtfh_pkg::tbl_rd_t                  rd_i,
  output logic [mtfh_pkg::IDX_W-1:0]         rd_mutex_o,
  output logic [mtfh_pkg::IDX_W-1:0]         rd_thread_o,
  output mtfh_pkg::tbl_wr_t                  wr_o,
  output mtfh_pkg::result_t                  res_o
);

  logic [mtfh_pkg::IDX_W-1:0] m_idx;
  logic [mtfh_pkg::IDX_W-1:0] t_idx;
  logic                       args_ok;
  mtfh_pkg::tbl_wr_t          wr;

  assign m_idx       = mtfh_pkg::IDX_W'(lock_id_i - mtfh_pkg::LOCK_ID_W'(1));
  assign t_idx       = mtfh_pkg::IDX_W'(thread_id_i);
  assign rd_mutex_o  = m_idx;
  assign rd_thread_o = t_idx;

  // Lock and unlock need a created mutex and a thread in range.
  assign args_ok = (lock_id_i != '0) && (32'(lock_id_i) <= 32'(created_i)) &&
                   (32'(thread_id_i) < THREAD_COUNT);

  // Work out the request outcome.
  always_comb begin
    wr                = '0;
    wr.row            = rd_i.row;
    wr.row_idx        = m_idx;
    wr.link_idx       = rd_i.row.tail;
    wr.link           = t_idx;
    wr.wait_idx       = t_idx;
    res_o             = '0;
    res_o.status      = mtfh_pkg::ST_INVALID;
    unique case (action_i)
      mtfh_pkg::ACT_CREATE: begin
        if (32'(created_i) < MUTEX_COUNT) begin
          wr.cnt_inc        = 1'b1;
          res_o.new_lock_id = mtfh_pkg::LOCK_ID_W'(32'(created_i) + 32'd1);
          res_o.status      = mtfh_pkg::ST_OK;
        end else begin
          res_o.status = mtfh_pkg::ST_NO_RES;
        end
      end
      mtfh_pkg::ACT_LOCK: begin
        if (args_ok && !rd_i.waiting) begin
          res_o.status = mtfh_pkg::ST_OK;
          wr.row_we    = 1'b1;
          if (!rd_i.row.held) begin
            // Free mutex: grant at once.
            wr.row.held  = 1'b1;
            wr.row.owner = t_idx;
          end else begin
            // Held mutex: append the caller to the wait queue.
            if (rd_i.row.nonempty) begin
              wr.link_we = 1'b1;
            end else begin
              wr.row.head     = t_idx;
              wr.row.nonempty = 1'b1;
            end
            wr.row.tail          = t_idx;
            wr.wait_we           = 1'b1;
            wr.wait_val          = 1'b1;
            res_o.caller_blocked = 1'b1;
          end
        end
      end
      mtfh_pkg::ACT_UNLOCK: begin
        if (args_ok && rd_i.row.held && (rd_i.row.owner == t_idx)) begin
          res_o.status = mtfh_pkg::ST_OK;
          wr.row_we    = 1'b1;
          if (rd_i.row.nonempty) begin
            // Hand ownership to the head waiter and pop it.
            wr.row.owner = rd_i.row.head;
            wr.wait_we   = 1'b1;
            wr.wait_idx  = rd_i.row.head;
            wr.wait_val  = 1'b0;
            if (rd_i.row.head == rd_i.row.tail) begin
              wr.row.nonempty = 1'b0;
            end else begin
              wr.row.head = rd_i.head_link;
            end
            res_o.woken_valid  = 1'b1;
            res_o.woken_thread = rd_i.row.head[mtfh_pkg::THREAD_ID_W-1:0];
          end else begin
            wr.row.held  = 1'b0;
            wr.row.owner = '0;
          end
        end
      end
      default: begin
        res_o.status = mtfh_pkg::ST_INVALID;
      end
    endcase
  end

  // Table writes happen only for the request being processed this cycle.
  always_comb begin
    wr_o         = wr;
    wr_o.row_we  = wr.row_we & en_i;
    wr_o.link_we = wr.link_we & en_i;
    wr_o.wait_we = wr.wait_we & en_i;
    wr_o.cnt_inc = wr.cnt_inc & en_i;
  end

endmodule

FILE: rtl/core/mutex_table_fifo_handoff_core.sv
// Hardware mutex manager with a FIFO wait queue per mutex: top level.
//
// Each request beat (create, lock or unlock with the calling thread) yields exactly one
// response beat. A request sits in an input register, then one pass through the
// per-mutex and per-thread tables updates state and loads the response register, which
// then offers the response beat; one request is taken every cycle while the response
// side does not stall, a rate set by that single table pass. While a response waits,
// the input register still takes a beat if it is empty, or if the response register
// frees up in the same cycle. Tables need no clearing pass after reset.
`include "mutex_table_fifo_handoff_core_assert.svh"

module mutex_table_fifo_handoff_core #(
  parameter int unsigned MUTEX_COUNT  = mtfh_pkg::MUTEX_COUNT_DEF,
  parameter int unsigned THREAD_COUNT = mtfh_pkg::THREAD_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from low: lock_id[4:0], thread_id[8:5], zero fill.
  input  logic [15:0] s_axis_tdata,
  // Bits from low: action[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from low: status[1:0], caller_blocked[2], new_lock_id[7:3],
  // woken_valid[8], woken_thread[12:9], zero fill.
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(MUTEX_COUNT + 1);
  localparam int unsigned ResW = $bits(mtfh_pkg::result_t);

  logic                               in_valid_q, in_valid_d;
  logic [mtfh_pkg::ACTION_W-1:0]      action_q;
  logic [mtfh_pkg::LOCK_ID_W-1:0]     lock_id_q;
  logic [mtfh_pkg::THREAD_ID_W-1:0]   thread_id_q;
  logic                               out_valid_q, out_valid_d;
  mtfh_pkg::result_t                  res_q, res_d;
  logic                               proc_fire;
  logic                               in_fire;
  logic [CntW-1:0]                    created_cnt;
  logic [mtfh_pkg::IDX_W-1:0]         rd_mutex;
  logic [mtfh_pkg::IDX_W-1:0]         rd_thread;
  mtfh_pkg::tbl_rd_t                  tbl_rd;
  mtfh_pkg::tbl_wr_t                  tbl_wr;

  // Handshake: process the held request whenever the response register can take it.
  assign proc_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_fire || (in_valid_q && !proc_fire);
  assign out_valid_d   = proc_fire || (out_valid_q && !m_axis_tready);

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q    <= s_axis_tuser[mtfh_pkg::ACTION_W-1:0];
      lock_id_q   <= s_axis_tdata[mtfh_pkg::LOCK_ID_W-1:0];
      thread_id_q <= s_axis_tdata[mtfh_pkg::LOCK_ID_W +: mtfh_pkg::THREAD_ID_W];
    end
    if (proc_fire) begin
      res_q <= res_d;
    end
  end

  mtfh_decide #(
    .MUTEX_COUNT  (MUTEX_COUNT),
    .THREAD_COUNT (THREAD_COUNT)
  ) u_decide (
    .en_i        (proc_fire),
    .action_i    (action_q),
    .lock_id_i   (lock_id_q),
    .thread_id_i (thread_id_q),
    .created_i   (created_cnt),
    .rd_i        (tbl_rd),
    .rd_mutex_o  (rd_mutex),
    .rd_thread_o (rd_thread),
    .wr_o        (tbl_wr),
    .res_o       (res_d)
  );

  mtfh_tables #(
    .MUTEX_COUNT  (MUTEX_COUNT),
    .THREAD_COUNT (THREAD_COUNT)
  ) u_tables (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_mutex_i  (rd_mutex),
    .rd_thread_i (rd_thread),
    .wr_i        (tbl_wr),
    .rd_o        (tbl_rd),
    .created_o   (created_cnt)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - ResW)'(0), res_q};

  // Checks on the counter, the response register and the handoff result.
  `MTFH_ASSERT_SAME(a_cnt_bound, clk_i, rst_ni, 1'b1, 32'(created_cnt) <= MUTEX_COUNT)
  `MTFH_ASSERT_NEXT(a_proc_loads_out, clk_i, rst_ni, proc_fire, out_valid_q)
  `MTFH_ASSERT_SAME(a_wake_is_ok, clk_i, rst_ni, out_valid_q && res_q.woken_valid,
                    res_q.status == mtfh_pkg::ST_OK && res_q.new_lock_id == '0)
  `MTFH_ASSERT_NEXT(a_create_counts, clk_i, rst_ni,
                    proc_fire && action_q == mtfh_pkg::ACT_CREATE &&
                    32'(created_cnt) < MUTEX_COUNT,
                    created_cnt == $past(created_cnt) + CntW'(1))

endmodule
